/* sv/krmt_pkg.sv */
// Package for the keyed running mean table: payload structs and the
// controller/datapath command and status structs. No dependencies.
package krmt_pkg;

    typedef struct packed {
        logic        kind;
        logic        arch;
        logic [31:0] footprint;
        logic [31:0] sample_time;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [31:0] mean_time;
        logic [15:0] samples;
        logic        table_full;
    } t_out_item;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;       // capture the accepted item, clear search state
        logic rd;         // read the entry at the scan index
        logic chk;        // compare the registered read data
        logic step;       // advance the scan index
        logic mul;        // form mean*n + m
        logic div_start;  // begin the serial divide
        logic div_step;   // one quotient bit
        logic wr_new;     // write a new entry at the free slot
        logic wr_upd;     // write back the updated mean and count
        logic res_miss;   // build a lookup-miss or full result
        logic res_hit;    // build a lookup-hit result
        logic res_new;    // build a new-entry result
        logic res_upd;    // build an update result
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic found;      // key matched during the scan
        logic free_found; // a free slot was seen
        logic scan_last;  // scan index is at the last entry
        logic div_done;   // divide finished
    } t_sts;

endpackage

/* sv/keyed_running_mean_table_top.sv */
// Top level of the keyed running mean table: controller plus datapath.
// Depends on krmt_pkg, krmt_ctrl, krmt_datapath, krmt_ram.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_in  (t_in_item)
//   output    o_out_valid / i_out_ready  o_out (t_out_item)
//
// Each transfer is processed alone. The key search reads the entries one at a
// time through the registered entry RAMs, in a read state and then a check
// state, and always scans every entry of the item's arch. An update of a
// present key adds a multiply and a restoring divide of 32+COUNT_BITS steps,
// one quotient bit per cycle. Reset is synchronous and clears only the
// control state and valid bits; the entry RAMs need no clearing. The result
// waits in an output register; a stalled output blocks the next input
// transfer only until it is taken.
module keyed_running_mean_table_top import krmt_pkg::*; #(
    parameter int ENTRIES_PER_ARCH = 64,
    parameter int COUNT_BITS       = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    krmt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid,
        .i_out_ready, .i_sts(w_sts), .o_cmd(w_cmd));

    krmt_datapath #(.ENTRIES_PER_ARCH(ENTRIES_PER_ARCH), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in), .i_cmd(w_cmd), .o_sts(w_sts), .o_res(o_out));
endmodule

/* sv/krmt_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module krmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* sv/krmt_datapath.sv */
// Datapath: entry memories, valid bits, scan index, multiplier and
// serial divider. Depends on krmt_pkg and krmt_ram.
module krmt_datapath import krmt_pkg::*; #(
    parameter int ENTRIES_PER_ARCH = 64,
    parameter int COUNT_BITS       = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_res
);
    localparam int IW    = $clog2(ENTRIES_PER_ARCH);
    // Each table gets a power-of-two region so that {arch, slot} is a valid address.
    localparam int TOTAL = 2 * (1 << IW);
    localparam int AW    = $clog2(TOTAL);
    localparam int NW    = 32 + COUNT_BITS;     // numerator width
    localparam int DW    = COUNT_BITS + 1;      // divisor width
    localparam int CW    = $clog2(NW + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_in_item               r_item;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_hit_idx, r_free_idx;
    logic                   r_found, r_free_found;
    logic [TOTAL-1:0]       r_valid;
    logic                   r_rd_valid;
    logic [31:0]            r_mean;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [NW-1:0]          r_num;      // numerator, shifted into quotient
    logic [DW-1:0]          r_rem;
    logic [CW-1:0]          r_dcnt;
    t_out_item              r_res;

    logic [AW-1:0]          w_addr;
    logic [IW-1:0]          w_slot;
    logic                   w_we;
    logic [31:0]            w_key_q, w_mean_q, w_mean_d;
    logic [COUNT_BITS-1:0]  w_cnt_q, w_cnt_d;
    logic [DW:0]            w_trial;
    logic [DW-1:0]          w_div;

    assign w_slot = i_cmd.wr_new ? r_free_idx : (i_cmd.wr_upd ? r_hit_idx : r_idx);
    assign w_addr = {r_item.arch, w_slot};
    assign w_we   = i_cmd.wr_new | i_cmd.wr_upd;
    assign w_cnt_d  = i_cmd.wr_new ? COUNT_BITS'(1)
                    : ((r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1);
    assign w_mean_d = i_cmd.wr_new ? r_item.sample_time : r_num[31:0];
    assign w_div    = {1'b0, r_cnt} + 1'b1;
    assign w_trial  = {r_rem, r_num[NW-1]};

    krmt_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_key (
        .i_clk, .i_we(i_cmd.wr_new), .i_addr(w_addr),
        .i_wdata(r_item.footprint), .o_rdata(w_key_q));
    krmt_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_mean (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_mean_d), .o_rdata(w_mean_q));
    krmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(TOTAL)) u_cnt (
        .i_clk, .i_we(w_we), .i_addr(w_addr), .i_wdata(w_cnt_d), .o_rdata(w_cnt_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_new) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item       <= i_item;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.chk) begin
            if (r_rd_valid && w_key_q == r_item.footprint && !r_found) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_idx;
                r_mean    <= w_mean_q;
                r_cnt     <= w_cnt_q;
            end
            if (!r_rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
        end
        if (i_cmd.mul) begin
            r_num <= NW'(r_mean) * NW'(r_cnt) + NW'(r_item.sample_time);
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dcnt <= CW'(NW);
        end
        if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, w_div}) begin
                r_rem <= DW'(w_trial - {1'b0, w_div});
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DW-1:0];
                r_num <= {r_num[NW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.res_miss) begin
            r_res <= '{hit: 1'b0, mean_time: '0, samples: '0,
                       table_full: r_item.kind};
        end
        if (i_cmd.res_hit) begin
            r_res <= '{hit: 1'b1, mean_time: r_mean,
                       samples: 16'(32'(r_cnt)), table_full: 1'b0};
        end
        if (i_cmd.res_new) begin
            r_res <= '{hit: 1'b0, mean_time: r_item.sample_time,
                       samples: 16'd1, table_full: 1'b0};
        end
        if (i_cmd.res_upd) begin
            r_res <= '{hit: 1'b1, mean_time: r_num[31:0],
                       samples: 16'(32'(w_cnt_d)), table_full: 1'b0};
        end
    end

    assign o_sts = '{kind: r_item.kind, found: r_found, free_found: r_free_found,
                     scan_last: (r_idx == IW'(ENTRIES_PER_ARCH - 1)),
                     div_done: (r_dcnt == '0)};
    assign o_res = r_res;
endmodule

/* sv/krmt_ctrl.sv */
// Controller state machine: sequences scan, multiply, divide, write back
// and result handoff. Depends on krmt_pkg.
module krmt_ctrl import krmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2,
                           S_DEC = 4'd3, S_MUL = 4'd4, S_DIVI = 4'd5,
                           S_DIV = 4'd6, S_WB = 4'd7, S_OUT = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Input is taken while idle when the result slot is empty or being drained.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_DEC: begin
                if (i_sts.found && i_sts.kind == KIND_UPDATE) begin
                    n_state = S_MUL;
                end else begin
                    if (i_sts.kind == KIND_LOOKUP) begin
                        o_cmd.res_hit  = i_sts.found;
                        o_cmd.res_miss = !i_sts.found;
                    end else if (i_sts.free_found) begin
                        o_cmd.wr_new  = 1'b1;
                        o_cmd.res_new = 1'b1;
                    end else begin
                        o_cmd.res_miss = 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WB;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WB: begin
                o_cmd.wr_upd  = 1'b1;
                o_cmd.res_upd = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
